// ===== rtl/lpae_page_table_walker_unit_defines.svh =====
// ----------------------------------------------------------------------------
// LPAE page table walker assertion macros
// Concurrent assertion wrappers clocked on clk_i, reset on rst_ni.
// ----------------------------------------------------------------------------
`ifndef LPAE_PAGE_TABLE_WALKER_UNIT_DEFINES_SVH
`define LPAE_PAGE_TABLE_WALKER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// checked only outside reset
`define LPW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked at every edge, reset included
`define LPW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define LPW_ASSERT(lbl, prop, msg)
`define LPW_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/lpw_pkg.sv =====
// ----------------------------------------------------------------------------
// lpw_pkg
// Shared types and constants of the LPAE page table walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpw_pkg;

  localparam int unsigned NUM_LEVELS = 4;
  localparam int unsigned ADDR_MAX   = 52;

  localparam logic [1:0] LAST_LEVEL      = 2'(NUM_LEVELS - 1);
  localparam logic [1:0] DESC_TYPE_BLOCK = 2'd1;
  localparam logic [1:0] DESC_TYPE_PAGE  = 2'd3;

  typedef enum logic {
    KIND_TRANSLATE = 1'b0,
    KIND_RESPONSE  = 1'b1
  } lpw_kind_e;

  typedef enum logic {
    RES_READ = 1'b0,
    RES_DONE = 1'b1
  } lpw_res_e;

  typedef enum logic [1:0] {
    REG_FIRST_LVL       = 2'd0,
    REG_LVL_IDX_BITS    = 2'd1,
    REG_ROOT_INDEX_BITS = 2'd2,
    REG_ROOT_TABLE_BASE = 2'd3
  } lpw_reg_e;

  typedef struct packed {
    logic [1:0]          first_lvl;
    logic [3:0]          lvl_idx_bits;
    logic [4:0]          root_index_bits;
    logic [ADDR_MAX-1:0] root_table_base;
  } lpw_cfg_t;

  // one classified item: addr holds the input address of a translate
  // request, or the unpacked output address of a descriptor
  typedef struct packed {
    lpw_kind_e           kind;
    logic                desc_zero;
    logic [1:0]          desc_type;
    logic [ADDR_MAX-1:0] addr;
  } lpw_item_t;

endpackage

`default_nettype wire

// ===== rtl/lpw_cfg.sv =====
// ----------------------------------------------------------------------------
// lpw_cfg
// APB register file: start level, granule index width, root index width and
// root table base.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpw_cfg
  import lpw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  output lpw_cfg_t         cfg_o
);

  lpw_cfg_t cfg_q, cfg_d;
  lpw_reg_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = lpw_reg_e'(paddr[4:3]);
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        REG_FIRST_LVL:       cfg_d.first_lvl       = pwdata[1:0];
        REG_LVL_IDX_BITS:    cfg_d.lvl_idx_bits    = pwdata[3:0];
        REG_ROOT_INDEX_BITS: cfg_d.root_index_bits = pwdata[4:0];
        REG_ROOT_TABLE_BASE: cfg_d.root_table_base = pwdata[ADDR_MAX-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FIRST_LVL:       prdata = 64'(cfg_q.first_lvl);
      REG_LVL_IDX_BITS:    prdata = 64'(cfg_q.lvl_idx_bits);
      REG_ROOT_INDEX_BITS: prdata = 64'(cfg_q.root_index_bits);
      REG_ROOT_TABLE_BASE: prdata = 64'(cfg_q.root_table_base);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_lvl       <= 2'd0;
      cfg_q.lvl_idx_bits    <= 4'd9;
      cfg_q.root_index_bits <= 5'd9;
      cfg_q.root_table_base <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/lpw_front.sv =====
// ----------------------------------------------------------------------------
// lpw_front
// Accepts requests and descriptor responses, pre-decodes descriptors and
// buffers the items in a two-entry queue for the walk engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "lpae_page_table_walker_unit_defines.svh"

module lpw_front
  import lpw_pkg::*;
#(
  parameter int unsigned ADDR_BITS = 52
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [3:0]           lvl_idx_bits_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 kind_i,
  input  wire logic [ADDR_BITS-1:0] io_address_i,
  input  wire logic [63:0]          descriptor_i,
  output logic                      head_valid_o,
  output lpw_item_t                 head_o,
  input  wire logic                 pop_i
);

  localparam logic [3:0] BPL_64K = 4'd13;

  lpw_item_t  mem_q [2];
  lpw_item_t  item;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic [ADDR_MAX-1:0] oa;

  // output address field; 64K granule packs bits 51:48 into bits 15:12
  always_comb begin
    if (lvl_idx_bits_i >= BPL_64K) begin
      oa = {descriptor_i[15:12], descriptor_i[47:16], 16'b0};
    end else begin
      oa = {4'b0, descriptor_i[47:12], 12'b0};
    end
  end

  always_comb begin
    item.kind      = lpw_kind_e'(kind_i);
    item.desc_zero = (descriptor_i == 64'd0);
    item.desc_type = descriptor_i[1:0];
    item.addr      = (item.kind == KIND_TRANSLATE) ? ADDR_MAX'(io_address_i) : oa;
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  `LPW_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= 2'd2, "queue count overflow")
  `LPW_ASSERT(a_pop_nonempty, pop_i |-> cnt_q != 2'd0, "pop from empty queue")
  `LPW_ASSERT(a_push_count, push && !pop_i |=> cnt_q == $past(cnt_q) + 2'd1,
              "push lost")

endmodule

`default_nettype wire

// ===== rtl/lpw_back.sv =====
// ----------------------------------------------------------------------------
// lpw_back
// Walk engine: holds the walk state, resolves each queued item and drives
// the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "lpae_page_table_walker_unit_defines.svh"

module lpw_back
  import lpw_pkg::*;
#(
  parameter int unsigned ADDR_BITS = 52
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire lpw_cfg_t             cfg_i,
  input  wire logic                 head_valid_i,
  input  wire lpw_item_t            head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      result_kind_o,
  output logic [ADDR_BITS-1:0]      address_o,
  output logic                      fault_o,
  output logic [1:0]                level_o
);

  // bit position of the index field of a level
  function automatic logic [5:0] level_shift(logic [1:0] lvl, logic [3:0] bpl);
    logic [6:0] prod;
    prod = 7'(3'd4 - 3'(lvl)) * 7'(bpl) + 7'd3;
    return prod[5:0];
  endfunction

  logic                 busy_q, busy_d;
  logic [ADDR_BITS-1:0] held_q, held_d;
  logic [1:0]           lvl_q, lvl_d;

  logic                 out_valid_q, out_valid_d;
  lpw_res_e             res_kind_q, res_kind_d;
  logic [ADDR_BITS-1:0] addr_q, addr_d;
  logic                 fault_q, fault_d;
  logic [1:0]           out_lvl_q, out_lvl_d;

  logic start_walk, resp, last, leaf, descend, finish, produce;
  logic [ADDR_BITS-1:0] sel_held, sel_table, rd_addr, leaf_addr;
  logic [1:0]           sel_lvl;
  logic [4:0]           idx_width;
  logic [5:0]           rd_shift, leaf_shift;
  logic [63:0]          idx, rd_sum, off;

  assign pop_o = head_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    start_walk = (head_i.kind == KIND_TRANSLATE) && !busy_q;
    resp       = (head_i.kind == KIND_RESPONSE) && busy_q;
    last       = (lvl_q == LAST_LEVEL);
    leaf       = last ? (head_i.desc_type == DESC_TYPE_PAGE)
                      : (head_i.desc_type == DESC_TYPE_BLOCK);
    descend    = resp && !head_i.desc_zero && !leaf && !last;
    finish     = resp && !descend;
    produce    = start_walk || resp;
  end

  // descriptor address of the next read: table + index * 8
  always_comb begin
    sel_held  = start_walk ? ADDR_BITS'(head_i.addr) : held_q;
    sel_lvl   = start_walk ? cfg_i.first_lvl : lvl_q + 2'd1;
    sel_table = start_walk ? ADDR_BITS'(cfg_i.root_table_base) : ADDR_BITS'(head_i.addr);
    idx_width = (sel_lvl == cfg_i.first_lvl) ? cfg_i.root_index_bits
                                             : 5'(cfg_i.lvl_idx_bits);
    rd_shift  = level_shift(sel_lvl, cfg_i.lvl_idx_bits);
    idx       = (64'(sel_held) >> rd_shift) & ((64'd1 << idx_width) - 64'd1);
    rd_sum    = 64'(sel_table) + (idx << 3);
    rd_addr   = rd_sum[ADDR_BITS-1:0];
  end

  // leaf: output address plus the in-block offset of the input address
  always_comb begin
    leaf_shift = level_shift(lvl_q, cfg_i.lvl_idx_bits);
    off        = 64'(held_q) & ((64'd1 << leaf_shift) - 64'd1);
    leaf_addr  = ADDR_BITS'(head_i.addr) | off[ADDR_BITS-1:0];
  end

  always_comb begin
    busy_d = busy_q;
    held_d = held_q;
    lvl_d  = lvl_q;
    if (pop_o) begin
      if (start_walk) begin
        busy_d = 1'b1;
        held_d = sel_held;
        lvl_d  = cfg_i.first_lvl;
      end else if (descend) begin
        lvl_d = sel_lvl;
      end else if (finish) begin
        busy_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    res_kind_d  = res_kind_q;
    addr_d      = addr_q;
    fault_d     = fault_q;
    out_lvl_d   = out_lvl_q;
    if (pop_o && produce) begin
      out_valid_d = 1'b1;
      if (start_walk || descend) begin
        res_kind_d = RES_READ;
        addr_d     = rd_addr;
        fault_d    = 1'b0;
        out_lvl_d  = sel_lvl;
      end else if (leaf && !head_i.desc_zero) begin
        res_kind_d = RES_DONE;
        addr_d     = leaf_addr;
        fault_d    = 1'b0;
        out_lvl_d  = lvl_q;
      end else begin
        res_kind_d = RES_DONE;
        addr_d     = '0;
        fault_d    = 1'b1;
        out_lvl_d  = lvl_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      held_q      <= '0;
      lvl_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      held_q      <= held_d;
      lvl_q       <= lvl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_kind_q <= res_kind_d;
    addr_q     <= addr_d;
    fault_q    <= fault_d;
    out_lvl_q  <= out_lvl_d;
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = res_kind_q;
  assign address_o     = addr_q;
  assign fault_o       = fault_q;
  assign level_o       = out_lvl_q;

  `LPW_ASSERT(a_fault_zero_addr, out_valid_q && fault_q |-> addr_q == '0,
              "faulting walk with nonzero address")
  `LPW_ASSERT(a_read_no_fault, out_valid_q && res_kind_q == RES_READ |-> !fault_q,
              "read request flagged as fault")
  `LPW_ASSERT(a_descend_level, pop_o && descend |=> busy_q && lvl_q == $past(lvl_q) + 2'd1,
              "descend did not advance level")
  `LPW_ASSERT(a_finish_idle, pop_o && finish |=> !busy_q,
              "walker still busy after finishing")

endmodule

`default_nettype wire

// ===== rtl/lpae_page_table_walker_unit.sv =====
// ----------------------------------------------------------------------------
// LPAE page table walker
// Walks ARMv8 long-descriptor translation tables, one level per response.
// ----------------------------------------------------------------------------
// A translate request (kind 0) starts a walk and yields a descriptor read
// request; each descriptor response (kind 1) yields the next read request or
// the final result (translated address, or fault with address zero). Requests
// while a walk is open and responses while idle are dropped without a result.
// One item is taken per clock while in_ready_o is high: a two-entry input queue
// feeds the walk engine, which resolves the head item combinationally into the
// result register, so an item passes the queue and then the result register
// before its result is valid. While the output stalls the queue fills its two
// entries before in_ready_o drops. Configure only while no walk is open.
`timescale 1ns / 1ps
`default_nettype none

module lpae_page_table_walker_unit
  import lpw_pkg::*;
#(
  parameter int unsigned ADDR_BITS = 52
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [4:0]           paddr,
  input  wire logic [63:0]          pwdata,
  output logic      [63:0]          prdata,
  output logic                      pready,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 kind_i,
  input  wire logic [ADDR_BITS-1:0] io_address_i,
  input  wire logic [63:0]          descriptor_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      result_kind_o,
  output logic [ADDR_BITS-1:0]      address_o,
  output logic                      fault_o,
  output logic [1:0]                level_o
);

  lpw_cfg_t  cfg;
  lpw_item_t head;
  logic      head_valid;
  logic      pop;

  lpw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lpw_front #(
    .ADDR_BITS (ADDR_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .lvl_idx_bits_i   (cfg.lvl_idx_bits),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .io_address_i     (io_address_i),
    .descriptor_i     (descriptor_i),
    .head_valid_o     (head_valid),
    .head_o           (head),
    .pop_i            (pop)
  );

  lpw_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .address_o     (address_o),
    .fault_o       (fault_o),
    .level_o       (level_o)
  );

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LPAE page table walker testbench
// Drives translate requests and descriptor responses into the walker and
// predicts each read request and walk result from a cycle-free model of the
// table walk. Covers directed corner walks, register writes with read-back,
// and random walks over several granule and start-level settings, most of them
// under random source gaps and sink stalls.
// ----------------------------------------------------------------------------

module testbench;
  import lpw_pkg::*;

  localparam int unsigned     RANDOM_ITEMS   = 400;
  localparam int unsigned     RANDOM_PHASES  = 9;
  localparam int unsigned     DRAIN_CYCLES   = 8;
  localparam int unsigned     GRANULE_64K    = 13;
  localparam int unsigned     HIGH_PA_SHIFT  = 36;
  localparam logic [63:0]     OA_MASK        = 64'h0000_FFFF_FFFF_F000;
  localparam logic [ADDR_MAX-1:0] PA_ALL_ONES = '1;

  typedef struct packed {
    lpw_res_e            kind;
    logic [ADDR_MAX-1:0] addr;
    logic                fault;
    logic [1:0]          level;
  } walk_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel, penable, pwrite, pready;
  logic [4:0]          paddr;
  logic [63:0]         pwdata, prdata;
  logic                in_valid_i, in_ready_o, kind_i;
  logic [ADDR_MAX-1:0] io_address_i;
  logic [63:0]         descriptor_i;
  logic                out_valid_o, out_ready_i = 1'b0;
  logic                result_kind_o, fault_o;
  logic [ADDR_MAX-1:0] address_o;
  logic [1:0]          level_o;

  // walker shadow state
  lpw_cfg_t            cfg;
  bit                  walking;
  logic [ADDR_MAX-1:0] held_address;
  logic [1:0]          walk_level;
  logic [ADDR_MAX-1:0] current_table;

  walk_result_t        walk_results_due[$];
  walk_result_t        due;
  int unsigned         send_idle_pct, recv_stall_pct;
  int unsigned         mismatches, walk_items, results_seen, translations, faults;
  int unsigned         settings_used;

  lpae_page_table_walker_unit dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .kind_i, .io_address_i, .descriptor_i,
    .out_valid_o, .out_ready_i, .result_kind_o, .address_o, .fault_o, .level_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL lpae_page_table_walker_unit");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic int unsigned level_shift(logic [1:0] lvl);
    return (NUM_LEVELS - int'(lvl)) * int'(cfg.lvl_idx_bits) + 3;
  endfunction

  function automatic logic [ADDR_MAX-1:0] descriptor_addr();
    int unsigned width;
    logic [63:0] idx;
    width = (walk_level == cfg.first_lvl) ? cfg.root_index_bits : cfg.lvl_idx_bits;
    idx = (64'(held_address) >> level_shift(walk_level)) & ((64'd1 << width) - 64'd1);
    return ADDR_MAX'(64'(current_table) + idx * 64'd8);
  endfunction

  // 64K granule keeps PA[51:48] in descriptor bits 15:12
  function automatic logic [ADDR_MAX-1:0] output_addr(logic [63:0] d);
    logic [63:0] pa;
    pa = d & OA_MASK;
    if (cfg.lvl_idx_bits < GRANULE_64K) return pa[ADDR_MAX-1:0];
    pa = (pa | (pa << HIGH_PA_SHIFT)) & (OA_MASK << 4);
    return pa[ADDR_MAX-1:0];
  endfunction

  function automatic bit next_walk_result(lpw_kind_e k, logic [ADDR_MAX-1:0] ioa,
                                          logic [63:0] d, output walk_result_t r);
    bit last, leaf;
    logic [63:0] off;
    r = '0;
    if (k == KIND_TRANSLATE) begin
      if (walking) return 0;
      walking       = 1;
      held_address  = ioa;
      walk_level    = cfg.first_lvl;
      current_table = cfg.root_table_base;
      r.kind  = RES_READ;
      r.addr  = descriptor_addr();
      r.level = walk_level;
      return 1;
    end
    if (!walking) return 0;
    last    = (walk_level == LAST_LEVEL);
    leaf    = last ? (d[1:0] == DESC_TYPE_PAGE) : (d[1:0] == DESC_TYPE_BLOCK);
    r.level = walk_level;
    if (d == '0 || (last && !leaf)) begin
      walking = 0;
      r.kind  = RES_DONE;
      r.fault = 1'b1;
      return 1;
    end
    if (leaf) begin
      off     = 64'(held_address) & ((64'd1 << level_shift(walk_level)) - 64'd1);
      walking = 0;
      r.kind  = RES_DONE;
      r.addr  = output_addr(d) | off[ADDR_MAX-1:0];
      return 1;
    end
    current_table = output_addr(d);
    walk_level    = walk_level + 2'd1;
    r.kind  = RES_READ;
    r.addr  = descriptor_addr();
    r.level = walk_level;
    return 1;
  endfunction

  // ------------------------------------------------------------------ checker
  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (walk_results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %b addr %h fault %b level %0d",
                 $time, result_kind_o, address_o, fault_o, level_o);
        mismatches++;
      end else begin
        due = walk_results_due.pop_front();
        check_field("result_kind", 64'(due.kind), 64'(result_kind_o));
        check_field("address", 64'(due.addr), 64'(address_o));
        check_field("fault", 64'(due.fault), 64'(fault_o));
        check_field("level", 64'(due.level), 64'(level_o));
        if (due.kind == RES_DONE && due.fault) faults++;
        else if (due.kind == RES_DONE) translations++;
      end
    end
  end

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  // --------------------------------------------------------------- transfers
  // entered and left at a falling edge; valid stays high between back-to-back items
  task automatic send_item(lpw_kind_e k, logic [ADDR_MAX-1:0] ioa, logic [63:0] d);
    walk_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= k;
    io_address_i <= ioa;
    descriptor_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
    if (next_walk_result(k, ioa, d, r)) begin
      walk_results_due.push_back(r);
      walk_items++;
    end
    @(negedge clk_i);
  endtask

  // closes any open walk, then holds off until every result is back
  task automatic settle_walker();
    if (walking) send_item(KIND_RESPONSE, '0, '0);
    in_valid_i <= 1'b0;
    while (walk_results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(lpw_reg_e idx, logic [63:0] value);
    logic [63:0] held;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_FIRST_LVL: begin
        cfg.first_lvl = value[1:0];
        held = 64'(cfg.first_lvl);
      end
      REG_LVL_IDX_BITS: begin
        cfg.lvl_idx_bits = value[3:0];
        held = 64'(cfg.lvl_idx_bits);
      end
      REG_ROOT_INDEX_BITS: begin
        cfg.root_index_bits = value[4:0];
        held = 64'(cfg.root_index_bits);
      end
      default: begin
        cfg.root_table_base = value[ADDR_MAX-1:0];
        held = 64'(cfg.root_table_base);
      end
    endcase
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("register read-back", held, prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_walk_config(logic [1:0] start, logic [3:0] bpl, logic [4:0] rib,
                                 logic [ADDR_MAX-1:0] base);
    settle_walker();
    write_reg(REG_FIRST_LVL, 64'(start));
    write_reg(REG_LVL_IDX_BITS, 64'(bpl));
    write_reg(REG_ROOT_INDEX_BITS, 64'(rib));
    write_reg(REG_ROOT_TABLE_BASE, 64'(base));
    settings_used++;
  endtask

  function automatic logic [63:0] pick_descriptor(logic [1:0] lvl);
    logic [63:0] d;
    logic [1:0] t;
    int unsigned roll;
    d    = {$urandom, $urandom};
    roll = $urandom_range(99);
    if (roll < 12) return '0;
    if (roll < 45) begin
      d[1:0] = (lvl == LAST_LEVEL) ? DESC_TYPE_PAGE : DESC_TYPE_BLOCK;
    end else begin
      // table pointer above the last level, exhausted entry at it
      t = 2'($urandom_range(2));
      if (lvl != LAST_LEVEL && t == DESC_TYPE_BLOCK) t = DESC_TYPE_PAGE;
      d[1:0] = t;
    end
    return d;
  endfunction

  // -------------------------------------------------------------------- tests
  task automatic test_register_access();
    set_walk_config(2'd0, 4'd0, 5'd0, '0);
    set_walk_config(2'd3, 4'd15, 5'd31, PA_ALL_ONES);
  endtask

  task automatic test_directed_walks();
    set_walk_config(2'd0, 4'd9, 5'd9, 52'h0_0000_8000_0000);
    send_item(KIND_RESPONSE, '0, 64'h0000_0000_1234_5003);   // idle: dropped
    send_item(KIND_TRANSLATE, PA_ALL_ONES, '0);
    send_item(KIND_TRANSLATE, 52'h0_1111_2222_3333, '0);      // busy: dropped
    send_item(KIND_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(KIND_RESPONSE, '0, 64'h0000_0000_4000_0003);
    send_item(KIND_RESPONSE, '0, 64'h0000_0012_3456_7002);
    send_item(KIND_RESPONSE, '0, 64'h0040_00AB_CDEF_1003);   // 4K page
    send_item(KIND_TRANSLATE, '0, '0);
    send_item(KIND_RESPONSE, '0, 64'h0000_0080_0000_0001);   // level 0 block
    send_item(KIND_TRANSLATE, 52'h5_A5A5_5A5A_A5A5, '0);
    send_item(KIND_RESPONSE, '0, '0);                         // empty entry
    send_item(KIND_TRANSLATE, 52'h0_7FFF_0000_1FFF, '0);
    send_item(KIND_RESPONSE, '0, 64'h0000_0001_0000_0003);
    send_item(KIND_RESPONSE, '0, 64'h0000_0002_0000_0003);
    send_item(KIND_RESPONSE, '0, 64'h0000_0003_0000_0003);
    send_item(KIND_RESPONSE, '0, 64'h0000_0004_0000_0001);   // exhausted at level 3

    set_walk_config(2'd1, 4'd13, 5'd6, 52'hF_0000_0001_0000);
    send_item(KIND_TRANSLATE, 52'h0_ABCD_1234_5678, '0);
    send_item(KIND_RESPONSE, '0, 64'h0000_1234_5678_F001);   // 64K block, high PA bits
    send_item(KIND_TRANSLATE, 52'hF_FEDC_BA98_7654, '0);
    send_item(KIND_RESPONSE, '0, 64'h0000_0000_0002_A003);
    send_item(KIND_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FFFD);

    set_walk_config(2'd3, 4'd11, 5'd17, 52'h0_0000_0000_0008);
    send_item(KIND_TRANSLATE, 52'h3_0000_0001_2345, '0);
    send_item(KIND_RESPONSE, '0, 64'h0000_0000_0000_1001);   // type 1 at level 3
    send_item(KIND_TRANSLATE, 52'h0_0000_001F_FFFF, '0);
    send_item(KIND_RESPONSE, '0, 64'h0000_7777_0000_0003);
    settle_walker();
  endtask

  task automatic test_random_walks();
    int unsigned phase_start;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_walk_config(2'd0, 4'd9, 5'd1, '0);
        1: set_walk_config(2'd3, 4'd13, 5'd17, PA_ALL_ONES);
        2: set_walk_config(2'd1, 4'd11, 5'd11, ADDR_MAX'({$urandom, $urandom}));
        3: set_walk_config(2'd2, 4'd15, 5'd31, ADDR_MAX'({$urandom, $urandom}));
        default: set_walk_config(2'($urandom_range(3)), 4'(9 + 2 * $urandom_range(2)),
                                 5'($urandom_range(1, 17)), ADDR_MAX'({$urandom, $urandom}));
      endcase
      case (p / 3)
        0: begin send_idle_pct = 20; recv_stall_pct = 57; end
        1: begin send_idle_pct = 57; recv_stall_pct = 20; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      phase_start = walk_items;
      while (walk_items - phase_start < RANDOM_ITEMS / RANDOM_PHASES) begin
        if ($urandom_range(99) < 85) begin
          send_item(KIND_TRANSLATE, ADDR_MAX'({$urandom, $urandom}), '0);
          while (walking) send_item(KIND_RESPONSE, ADDR_MAX'({$urandom, $urandom}),
                                    pick_descriptor(walk_level));
        end else begin
          send_item(lpw_kind_e'($urandom_range(1)), ADDR_MAX'({$urandom, $urandom}),
                    {$urandom, $urandom});
        end
      end
    end
    settle_walker();
  endtask

  initial begin
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    kind_i       = KIND_TRANSLATE;
    io_address_i = '0;
    descriptor_i = '0;
    cfg          = '{first_lvl: 2'd0, lvl_idx_bits: 4'd9, root_index_bits: 5'd9,
                     root_table_base: '0};
    walking      = 0;
    held_address = '0;
    walk_level   = '0;
    current_table = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_register_access();
    test_directed_walks();
    test_random_walks();

    $display("Covered %0d accepted items and %0d results over %0d register settings:",
             walk_items, results_seen, settings_used);
    $display("  %0d walks translated, %0d walks faulted", translations, faults);
    if (mismatches == 0) begin
      $display("PASS lpae_page_table_walker_unit");
    end else begin
      $display("FAIL lpae_page_table_walker_unit");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lpw_pkg.sv
rtl/lpw_cfg.sv
rtl/lpw_front.sv
rtl/lpw_back.sv
rtl/lpae_page_table_walker_unit.sv
test/testbench.sv
